// File: rtl/line_rasterizer_assert.svh
// assertion macros used by the line rasterizer top level
`ifndef LINE_RASTERIZER_ASSERT_SVH
`define LINE_RASTERIZER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lr_pkg.sv
// shared types and constants of the line rasterizer
`default_nettype none

package lr_pkg;

    localparam int COORD_BITS_DEF = 7;
    localparam int CFG_W          = 8;
    localparam int APB_ADDR_W     = 3;
    localparam int APB_DATA_W     = 32;
    localparam int IN_FIELD_W     = 8;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 8'd128;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 8'd64;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [CFG_W-1:0] width;
        logic [CFG_W-1:0] height;
    } cfg_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic rejected;
        logic second_valid;
        logic last;
    } res_flags_t;

endpackage

`default_nettype wire

// File: rtl/lr_regs.sv
// apb register file holding the screen limits
`default_nettype none

module lr_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lr_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [lr_pkg::APB_DATA_W-1:0] pwdata,
    output logic [lr_pkg::APB_DATA_W-1:0] prdata,
    output logic                        pready,
    output lr_pkg::cfg_t                cfg
);
    import lr_pkg::*;

    logic [CFG_W-1:0] width_reg, width_next;
    logic [CFG_W-1:0] height_reg, height_next;
    logic             wr_en;
    logic             reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = paddr[2];

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        prdata      = '0;
        case (reg_sel)
            REG_WIDTH:
            begin
                if (wr_en)
                begin
                    width_next = pwdata[CFG_W-1:0];
                end
                prdata = APB_DATA_W'(width_reg);
            end
            REG_HEIGHT:
            begin
                if (wr_en)
                begin
                    height_next = pwdata[CFG_W-1:0];
                end
                prdata = APB_DATA_W'(height_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    assign cfg.width  = width_reg;
    assign cfg.height = height_reg;

endmodule

`default_nettype wire

// File: rtl/lr_front.sv
// front end: bounds check and line setup for each incoming segment
`default_nettype none

module lr_front #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [4*lr_pkg::IN_FIELD_W-1:0] s_tdata,
    input  lr_pkg::cfg_t                cfg,
    input  lr_pkg::q_status_t           q_stat,
    output logic                        push,
    output logic [6*COORD_BITS+2:0]     job
);
    import lr_pkg::*;

    localparam int LW = (COORD_BITS + 1 > IN_FIELD_W + 1) ? COORD_BITS + 1 : IN_FIELD_W + 1;
    localparam logic [LW-1:0] LIMIT = LW'(1) << COORD_BITS;

    logic [IN_FIELD_W-1:0] xs, ys, xe, ye;
    logic [LW-1:0]         lim_w, lim_h, raw_w, raw_h;
    logic                  on_screen;
    logic [COORD_BITS-1:0] xs_c, ys_c, xe_c, ye_c;
    logic [COORD_BITS-1:0] dx, dy;
    logic                  sxn, syn;

    assign xs = s_tdata[IN_FIELD_W-1:0];
    assign ys = s_tdata[2*IN_FIELD_W-1:IN_FIELD_W];
    assign xe = s_tdata[3*IN_FIELD_W-1:2*IN_FIELD_W];
    assign ye = s_tdata[4*IN_FIELD_W-1:3*IN_FIELD_W];

    // limits saturate at the coordinate range
    assign raw_w = LW'(cfg.width);
    assign raw_h = LW'(cfg.height);
    assign lim_w = (raw_w > LIMIT) ? LIMIT : raw_w;
    assign lim_h = (raw_h > LIMIT) ? LIMIT : raw_h;

    assign on_screen = (LW'(xs) < lim_w) && (LW'(xe) < lim_w) &&
                       (LW'(ys) < lim_h) && (LW'(ye) < lim_h);

    assign xs_c = COORD_BITS'(xs);
    assign ys_c = COORD_BITS'(ys);
    assign xe_c = COORD_BITS'(xe);
    assign ye_c = COORD_BITS'(ye);

    assign dx  = (xe_c >= xs_c) ? xe_c - xs_c : xs_c - xe_c;
    assign dy  = (ye_c >= ys_c) ? ye_c - ys_c : ys_c - ye_c;
    assign sxn = !(xs_c < xe_c);
    assign syn = !(ys_c < ye_c);

    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && s_tready;
    assign job      = {!on_screen, sxn, syn, dy, dx, ye_c, xe_c, ys_c, xs_c};

endmodule

`default_nettype wire

// File: rtl/lr_queue.sv
// short fifo of set-up lines between front and back
`default_nettype none

module lr_queue #(
    parameter int WIDTH = 45
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              pop,
    output logic [WIDTH-1:0]  rdata,
    output lr_pkg::q_status_t q_stat
);
    import lr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    logic [WIDTH-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata        = entry_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == CNT_FULL);
    assign q_stat.empty = (count_reg == '0);

endmodule

`default_nettype wire

// File: rtl/lr_back.sv
// back end: two-step bresenham walk feeding the result register
`default_nettype none

module lr_back #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [6*COORD_BITS+2:0]     job,
    input  lr_pkg::q_status_t           q_stat,
    output logic                        pop,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [COORD_BITS-1:0]       first_x,
    output logic [COORD_BITS-1:0]       first_y,
    output logic [COORD_BITS-1:0]       second_x,
    output logic [COORD_BITS-1:0]       second_y,
    output lr_pkg::res_flags_t          flags
);
    import lr_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int EW   = COORD_BITS + 3;
    localparam int SW   = 2 * COORD_BITS + EW;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic                 st_reg, st_next;
    logic                 rej_reg, rej_next;
    logic [CB-1:0]        x_reg, x_next, y_reg, y_next;
    logic [CB-1:0]        tx_reg, tx_next, ty_reg, ty_next;
    logic [CB-1:0]        dx_reg, dx_next, dy_reg, dy_next;
    logic                 sxn_reg, sxn_next, syn_reg, syn_next;
    logic signed [EW-1:0] err_reg, err_next;

    logic                 out_valid_reg, out_valid_next;
    logic [CB-1:0]        fx_reg, fy_reg, sx_reg, sy_reg;
    logic [CB-1:0]        fx_next, fy_next, sx_next, sy_next;
    res_flags_t           flags_reg, flags_next;

    logic                 can_load, fire, done0, done1, is_last;
    logic [SW-1:0]        step1, step2;
    logic [CB-1:0]        x1, y1, x2, y2;
    logic signed [EW-1:0] e1, e2;

    logic [CB-1:0]        j_xs, j_ys, j_xe, j_ye, j_dx, j_dy;
    logic                 j_sxn, j_syn, j_rej;

    function automatic logic [SW-1:0] walk_step(
        input logic [CB-1:0]        x,
        input logic [CB-1:0]        y,
        input logic signed [EW-1:0] err,
        input logic [CB-1:0]        dx,
        input logic [CB-1:0]        dy,
        input logic                 sxn,
        input logic                 syn
    );
        logic signed [EW-1:0] dxs, dys, dbl, en;
        logic [CB-1:0]        xn, yn;
        dxs = $signed(EW'(dx));
        dys = $signed(EW'(dy));
        dbl = err <<< 1;
        en  = err;
        xn  = x;
        yn  = y;
        if (dbl >= -dys)
        begin
            en = en - dys;
            xn = sxn ? x - CB'(1) : x + CB'(1);
        end
        if (dbl <= dxs)
        begin
            en = en + dxs;
            yn = syn ? y - CB'(1) : y + CB'(1);
        end
        return {xn, yn, en};
    endfunction

    assign {j_rej, j_sxn, j_syn, j_dy, j_dx, j_ye, j_xe, j_ys, j_xs} = job;

    assign step1 = walk_step(x_reg, y_reg, err_reg, dx_reg, dy_reg, sxn_reg, syn_reg);
    assign {x1, y1, e1} = step1;
    assign step2 = walk_step(x1, y1, e1, dx_reg, dy_reg, sxn_reg, syn_reg);
    assign {x2, y2, e2} = step2;

    assign done0   = (x_reg == tx_reg) && (y_reg == ty_reg);
    assign done1   = (x1 == tx_reg) && (y1 == ty_reg);
    assign is_last = rej_reg || done0 || done1;

    assign can_load = !out_valid_reg || m_tready;
    assign fire     = (st_reg == ST_WALK) && can_load;
    assign pop      = (st_reg == ST_IDLE) && !q_stat.empty;

    always_comb
    begin
        st_next  = st_reg;
        rej_next = rej_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        tx_next  = tx_reg;
        ty_next  = ty_reg;
        dx_next  = dx_reg;
        dy_next  = dy_reg;
        sxn_next = sxn_reg;
        syn_next = syn_reg;
        err_next = err_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    st_next  = ST_WALK;
                    rej_next = j_rej;
                    x_next   = j_xs;
                    y_next   = j_ys;
                    tx_next  = j_xe;
                    ty_next  = j_ye;
                    dx_next  = j_dx;
                    dy_next  = j_dy;
                    sxn_next = j_sxn;
                    syn_next = j_syn;
                    err_next = $signed(EW'(j_dx)) - $signed(EW'(j_dy));
                end
            end
            ST_WALK:
            begin
                if (fire)
                begin
                    if (is_last)
                    begin
                        st_next = ST_IDLE;
                    end
                    else
                    begin
                        x_next   = x2;
                        y_next   = y2;
                        err_next = e2;
                    end
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        fx_next        = fx_reg;
        fy_next        = fy_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        flags_next     = flags_reg;
        if (can_load)
        begin
            out_valid_next = fire;
        end
        if (fire)
        begin
            flags_next.rejected     = rej_reg;
            flags_next.second_valid = !rej_reg && !done0;
            flags_next.last         = is_last;
            fx_next = rej_reg ? '0 : x_reg;
            fy_next = rej_reg ? '0 : y_reg;
            sx_next = (rej_reg || done0) ? '0 : x1;
            sy_next = (rej_reg || done0) ? '0 : y1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rej_reg   <= rej_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        tx_reg    <= tx_next;
        ty_reg    <= ty_next;
        dx_reg    <= dx_next;
        dy_reg    <= dy_next;
        sxn_reg   <= sxn_next;
        syn_reg   <= syn_next;
        err_reg   <= err_next;
        fx_reg    <= fx_next;
        fy_reg    <= fy_next;
        sx_reg    <= sx_next;
        sy_reg    <= sy_next;
        flags_reg <= flags_next;
    end

    assign m_tvalid = out_valid_reg;
    assign first_x  = fx_reg;
    assign first_y  = fy_reg;
    assign second_x = sx_reg;
    assign second_y = sy_reg;
    assign flags    = flags_reg;

endmodule

`default_nettype wire

// File: rtl/line_rasterizer.sv
// top level of the bresenham line rasterizer
//
//  channel  dir  beat contents
//  s_       in   one segment: x_start, y_start, x_end, y_end
//  m_       out  up to two pixels, pixel-valid and reject flags, tlast per line
//  apb      in   width limit at 0x0, height limit at 0x4
//
//  a line of n pixels is set up once, then yields ceil(n/2) result beats, 64 at most
//  an off-screen line is set up once, then yields a single beat
//  the walk loop retires two pixels per cycle unless the output stalls; a two-line queue decouples intake
//  no clearing pass after reset; m_tready low stalls the walk, intake stalls when
//  the queue is full
`default_nettype none

`include "line_rasterizer_assert.svh"

module line_rasterizer #(
    parameter int COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // x_start, y_start, x_end, y_end
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [4*lr_pkg::IN_FIELD_W-1:0] s_tdata,
    // first_px_x, first_px_y, second_px_x, second_px_y
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [((4*COORD_BITS+7)/8)*8-1:0] m_tdata,
    // second_valid, rejected
    output logic [1:0]                      m_tuser,
    output logic                            m_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [lr_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [lr_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [lr_pkg::APB_DATA_W-1:0]   prdata,
    output logic                            pready
);
    import lr_pkg::*;

    localparam int JOB_W   = 6 * COORD_BITS + 3;
    localparam int TDATA_W = ((4 * COORD_BITS + 7) / 8) * 8;

    cfg_t                  cfg;
    q_status_t             q_stat;
    logic                  q_push, q_pop;
    logic [JOB_W-1:0]      job_in, job_out;
    logic [COORD_BITS-1:0] first_x, first_y, second_x, second_y;
    res_flags_t            flags;
    logic                  out_rej;
    logic                  out_half;

    lr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .cfg      (cfg),
        .q_stat   (q_stat),
        .push     (q_push),
        .job      (job_in)
    );

    lr_queue #(
        .WIDTH (JOB_W)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (q_push),
        .wdata  (job_in),
        .pop    (q_pop),
        .rdata  (job_out),
        .q_stat (q_stat)
    );

    lr_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .job      (job_out),
        .q_stat   (q_stat),
        .pop      (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .first_x  (first_x),
        .first_y  (first_y),
        .second_x (second_x),
        .second_y (second_y),
        .flags    (flags)
    );

    assign m_tdata = TDATA_W'({second_y, second_x, first_y, first_x});
    assign m_tuser = {flags.rejected, flags.second_valid};
    assign m_tlast = flags.last;

    assign out_rej  = m_tvalid && flags.rejected;
    assign out_half = m_tvalid && !flags.second_valid;

    `LR_ASSERT_IMP(a_reject_single, out_rej, m_tlast && !flags.second_valid, "reject not last")
    `LR_ASSERT_IMP(a_reject_no_px, out_rej, m_tdata == '0, "rejected beat carries pixels")
    `LR_ASSERT_IMP(a_half_is_last, out_half, m_tlast, "half-filled beat before end of line")
    `LR_ASSERT_NEXT(a_queue_holds, q_push, !q_stat.empty, "accepted segment lost from queue")

endmodule

`default_nettype wire
